// ===== rtl/pmt_pkg.sv =====
package pmt_pkg;

	// Defaults and fixed field widths
	localparam int COUNT_BITS_DEF = 32;
	localparam int ELAPSED_BITS   = 16;
	localparam int COUNT_FIELD    = 32;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int MODE_BITS      = 3;

	localparam logic [CFG_DATA_BITS-1:0] PRESET_RESET  = 32'd1000;
	localparam logic [CFG_DATA_BITS-1:0] ON_TIME_RESET = 32'd0;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODE    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PRESET  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ON_TIME = 2'd2;

	// Timer modes; the unused selector code falls to on-delay
	typedef enum logic [MODE_BITS-1:0] {
		MODE_ON_DELAY  = 3'd0,
		MODE_OFF_DELAY = 3'd1,
		MODE_RETENTIVE = 3'd2,
		MODE_PULSE     = 3'd3,
		MODE_LATCHED   = 3'd4,
		MODE_RETRIG    = 3'd5,
		MODE_FLASHER   = 3'd6
	} mode_e_t;

	// Single-bit timer state
	typedef struct packed {
		logic done_flag;
		logic rise_arm;
		logic fall_arm;
		logic last_rise_pulse;
		logic control_latch;
		logic ctrl_rise_arm;
		logic ctrl_fall_arm;
	} flags_t;

	// One result item
	typedef struct packed {
		logic                   done_res;
		logic                   done_rose;
		logic                   done_fell;
		logic                   running;
		logic [COUNT_FIELD-1:0] count;
		logic                   flash_out;
	} result_t;

endpackage

// ===== rtl/pmt_scan_if.sv =====
interface pmt_scan_if;
	logic                              valid;
	logic                              ready;
	logic [pmt_pkg::ELAPSED_BITS-1:0]  elapsed;
	logic                              enable;
	logic                              reset_req;
	logic                              control;

	modport source (output valid, output elapsed, output enable, output reset_req,
		output control, input ready);
	modport sink (input valid, input elapsed, input enable, input reset_req,
		input control, output ready);
endinterface

// ===== rtl/pmt_result_if.sv =====
interface pmt_result_if;
	logic                             valid;
	logic                             ready;
	logic                             done_res;
	logic                             done_rose;
	logic                             done_fell;
	logic                             running;
	logic [pmt_pkg::COUNT_FIELD-1:0]  count;
	logic                             flash_out;

	modport source (output valid, output done_res, output done_rose, output done_fell,
		output running, output count, output flash_out, input ready);
	modport sink (input valid, input done_res, input done_rose, input done_fell,
		input running, input count, input flash_out, output ready);
endinterface

// ===== rtl/pmt_step.sv =====
// Next-state and result logic for one scan.
module pmt_step #(
	parameter int COUNT_BITS = pmt_pkg::COUNT_BITS_DEF
) (
	input  logic [pmt_pkg::MODE_BITS-1:0]     mode,
	input  logic [pmt_pkg::CFG_DATA_BITS-1:0] preset,
	input  logic [pmt_pkg::CFG_DATA_BITS-1:0] on_time,
	input  logic [COUNT_BITS-1:0]             acc,
	input  pmt_pkg::flags_t                   flags,
	input  logic [pmt_pkg::ELAPSED_BITS-1:0]  elapsed,
	input  logic                              enable,
	input  logic                              reset_req,
	input  logic                              control,
	output logic [COUNT_BITS-1:0]             acc_nxt,
	output pmt_pkg::flags_t                   flags_nxt,
	output pmt_pkg::result_t                  res
);
	import pmt_pkg::*;

	localparam int SW = ((COUNT_BITS > ELAPSED_BITS) ? COUNT_BITS : ELAPSED_BITS) + 1;
	localparam int CW = (COUNT_BITS > CFG_DATA_BITS) ? COUNT_BITS : CFG_DATA_BITS;
	localparam logic [SW-1:0] ACC_MASK = {{(SW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

	logic [SW-1:0]         sum;
	logic [COUNT_BITS-1:0] sat;
	logic [CW-1:0]         sat_w;
	logic [CW-1:0]         preset_w;
	logic [CW-1:0]         acc_nxt_w;
	logic [CW-1:0]         on_time_w;
	logic                  hit;
	logic                  ctrl;
	logic                  clear;
	logic                  done_n;
	logic                  running;
	logic                  rose;
	logic                  fell;

	assign sum       = SW'(acc) + SW'(elapsed);
	assign sat       = (sum > ACC_MASK) ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
	assign sat_w     = CW'(sat);
	assign preset_w  = CW'(preset);
	assign on_time_w = CW'(on_time);
	assign hit       = (sat_w >= preset_w);

	always_comb begin
		acc_nxt   = acc;
		flags_nxt = flags;
		done_n    = flags.done_flag;
		ctrl      = control;
		clear     = 1'b0;
		running   = 1'b0;
		if (mode == MODE_OFF_DELAY) begin
			flags_nxt.control_latch = control;
			if (!enable) begin
				acc_nxt = sat;
				if (hit) begin
					acc_nxt = preset_w[COUNT_BITS-1:0];
					done_n  = 1'b0;
				end
			end
			if (reset_req || enable) begin
				done_n  = 1'b1;
				acc_nxt = '0;
			end
			running = !enable && done_n && !reset_req;
		end else begin
			if (mode == MODE_LATCHED) begin
				ctrl = flags.control_latch || control;
			end
			if (enable || ctrl) begin
				acc_nxt = sat;
				if (hit) begin
					acc_nxt = preset_w[COUNT_BITS-1:0];
					done_n  = 1'b1;
				end
			end
			case (mode)
				MODE_RETENTIVE: clear = reset_req;
				MODE_PULSE:     clear = reset_req || flags.last_rise_pulse;
				MODE_LATCHED:   clear = reset_req && done_n;
				MODE_RETRIG: begin
					// Clear on either edge of control, or on reset_req
					clear = (ctrl && flags.ctrl_rise_arm) || (!ctrl && flags.ctrl_fall_arm)
						|| reset_req;
					flags_nxt.ctrl_rise_arm = !ctrl;
					flags_nxt.ctrl_fall_arm = ctrl;
				end
				MODE_FLASHER:   clear = !enable || flags.last_rise_pulse;
				default:        clear = reset_req || !enable;
			endcase
			if (clear) begin
				done_n  = 1'b0;
				acc_nxt = '0;
				ctrl    = 1'b0;
			end
			flags_nxt.control_latch = ctrl;
			running = (enable || ctrl) && !done_n && !reset_req;
		end

		rose = done_n && flags.rise_arm;
		fell = !done_n && flags.fall_arm;
		flags_nxt.done_flag       = done_n;
		flags_nxt.rise_arm        = !done_n;
		flags_nxt.fall_arm        = done_n;
		flags_nxt.last_rise_pulse = rose;
	end

	assign acc_nxt_w = CW'(acc_nxt);

	always_comb begin
		res.done_res  = done_n;
		res.done_rose = rose;
		res.done_fell = fell;
		res.running   = running;
		res.count     = acc_nxt_w[COUNT_FIELD-1:0];
		res.flash_out = (mode == MODE_FLASHER) && enable && (acc_nxt_w <= on_time_w);
	end

endmodule

// ===== rtl/multi_mode_plc_timer_unit.sv =====
// Scan-driven PLC timer with seven modes (on-delay, off-delay, retentive,
// pulse, latched, retriggerable, flasher).
// Channels: scan (sink) carries one scan per transfer: elapsed ticks and the
// enable, reset_req and control levels. result (source) carries one item per
// scan: done, its rise and fall pulses, running, count and flash_out.
// Configuration: write_en/write_index/write_data write mode (0), preset (1)
// and on_time (2); write only while no scan is in flight.
// Path: a scan is taken into the input register, then the next-state
// logic updates the timer state and loads the result register, which
// holds the result until it transfers.
// Throughput: one scan per cycle while result.ready is high; the single
// add/compare/flag update between the two registers sets that figure.
// Stall: while result.ready is low the result register holds; the input
// register still takes one more scan, then scan.ready drops until the result
// transfers.
// Reset: arst_n clears the timer state and both valid flags, and loads
// mode on-delay, preset 1000 and on_time 0.
module multi_mode_plc_timer_unit #(
	parameter int COUNT_BITS = pmt_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	pmt_scan_if.sink                            scan,
	pmt_result_if.source                        result,
	input  logic                                write_en,
	input  logic [pmt_pkg::CFG_IDX_BITS-1:0]    write_index,
	input  logic [pmt_pkg::CFG_DATA_BITS-1:0]   write_data
);
	import pmt_pkg::*;

	// Configuration registers
	logic [MODE_BITS-1:0]     mode_q;
	logic [CFG_DATA_BITS-1:0] preset_q;
	logic [CFG_DATA_BITS-1:0] on_time_q;

	// Timer state
	logic [COUNT_BITS-1:0] acc_q;
	logic [COUNT_BITS-1:0] acc_nxt;
	flags_t                flags_q;
	flags_t                flags_nxt;

	// Input register
	logic                    valid_s1;
	logic [ELAPSED_BITS-1:0] elapsed_s1;
	logic                    enable_s1;
	logic                    reset_req_s1;
	logic                    control_s1;

	// Result register
	logic    res_valid_q;
	result_t res_q;
	result_t res_nxt;

	logic advance;
	logic take;

	// Move the held scan on when the result register is free or emptying
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign scan.ready = !valid_s1 || advance;
	assign take       = scan.valid && scan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_ON_DELAY;
			preset_q  <= PRESET_RESET;
			on_time_q <= ON_TIME_RESET;
		end else if (write_en) begin
			case (write_index)
				CFG_MODE:    mode_q    <= write_data[MODE_BITS-1:0];
				CFG_PRESET:  preset_q  <= write_data;
				CFG_ON_TIME: on_time_q <= write_data;
				default:     ;
			endcase
		end
	end

	// Capture a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			elapsed_s1   <= scan.elapsed;
			enable_s1    <= scan.enable;
			reset_req_s1 <= scan.reset_req;
			control_s1   <= scan.control;
		end
	end

	pmt_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.mode      (mode_q),
		.preset    (preset_q),
		.on_time   (on_time_q),
		.acc       (acc_q),
		.flags     (flags_q),
		.elapsed   (elapsed_s1),
		.enable    (enable_s1),
		.reset_req (reset_req_s1),
		.control   (control_s1),
		.acc_nxt   (acc_nxt),
		.flags_nxt (flags_nxt),
		.res       (res_nxt)
	);

	// Advance the timer state once per scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			flags_q <= '0;
		end else if (advance) begin
			acc_q   <= acc_nxt;
			flags_q <= flags_nxt;
		end
	end

	// Hold the result until it transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.done_res  = res_q.done_res;
	assign result.done_rose = res_q.done_rose;
	assign result.done_fell = res_q.done_fell;
	assign result.running   = res_q.running;
	assign result.count     = res_q.count;
	assign result.flash_out = res_q.flash_out;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

	import pmt_pkg::*;

	// Accumulator width of the instance under test
	localparam int ACC_BITS = COUNT_BITS_DEF;
	// Selector code with no mode of its own; the block treats it as on-delay
	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 3'd7;
	// Generous bound on the whole run, in clock cycles
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic write_en;
	logic [CFG_IDX_BITS-1:0] write_index;
	logic [CFG_DATA_BITS-1:0] write_data;

	pmt_scan_if   scan_ch();
	pmt_result_if res_ch();

	multi_mode_plc_timer_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan        (scan_ch),
		.result      (res_ch),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data)
	);

	// 4 time-unit clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Timer settings as the block should hold them
	logic [MODE_BITS-1:0]     t_mode;
	logic [CFG_DATA_BITS-1:0] t_preset;
	logic [CFG_DATA_BITS-1:0] t_on_time;

	// Timer state as the block should hold it
	logic [ACC_BITS-1:0] t_acc;
	logic t_done;
	logic t_rise_arm;
	logic t_fall_arm;
	logic t_last_rise;
	logic t_ctrl_latch;
	logic t_ctrl_rise_arm;
	logic t_ctrl_fall_arm;

	// Timer outputs still owed by the block, oldest first
	result_t awaited[$];

	int unsigned src_idle;
	int unsigned snk_idle;
	int unsigned errors;
	int unsigned cycles;
	int unsigned scans_sent;
	int unsigned results_checked;
	int unsigned settings_used;
	int unsigned done_pulses;
	logic [7:0]  modes_seen;

	// Add with saturation at the all-ones accumulator value
	function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
		input logic [ELAPSED_BITS-1:0] b);
		logic [ACC_BITS:0] sum;
		sum = {1'b0, a} + b;
		if (sum[ACC_BITS])
			return '1;
		return sum[ACC_BITS-1:0];
	endfunction

	// Advance the timer by one scan and return the result it should produce
	function automatic result_t advance_timer(input logic [ELAPSED_BITS-1:0] el,
		input logic en, input logic rq, input logic ct);
		result_t r;
		logic [MODE_BITS-1:0] m;
		logic go, clr, up, dn, run, rose, fell;
		m = (t_mode == MODE_UNUSED) ? MODE_ON_DELAY : t_mode;
		clr = 1'b0;
		if (m == MODE_OFF_DELAY) begin
			// Off-delay times while enable is low and drops done at the preset
			t_ctrl_latch = ct;
			if (!en) begin
				t_acc = sat_add(t_acc, el);
				if (t_acc >= t_preset) begin
					t_acc  = t_preset;
					t_done = 1'b0;
				end
			end
			if (rq || en) begin
				t_done = 1'b1;
				t_acc  = '0;
			end
			run = !en && t_done && !rq;
		end else begin
			// Effective control level: latched mode keeps the start latch
			go = (m == MODE_LATCHED) ? (t_ctrl_latch || ct) : ct;
			if (en || go) begin
				t_acc = sat_add(t_acc, el);
				if (t_acc >= t_preset) begin
					t_acc  = t_preset;
					t_done = 1'b1;
				end
			end
			case (m)
				MODE_RETENTIVE: clr = rq;
				MODE_PULSE:     clr = rq || t_last_rise;
				MODE_LATCHED:   clr = rq && t_done;
				MODE_RETRIG: begin
					// Either edge of control restarts the timer
					up = go && t_ctrl_rise_arm;
					dn = !go && t_ctrl_fall_arm;
					t_ctrl_rise_arm = !go;
					t_ctrl_fall_arm = go;
					clr = up || dn || rq;
				end
				MODE_FLASHER:   clr = !en || t_last_rise;
				default:        clr = rq || !en;
			endcase
			if (clr) begin
				t_done = 1'b0;
				t_acc  = '0;
				go     = 1'b0;
			end
			t_ctrl_latch = go;
			run = (en || go) && !t_done && !rq;
		end
		rose = t_done && t_rise_arm;
		t_rise_arm = !t_done;
		fell = !t_done && t_fall_arm;
		t_fall_arm = t_done;
		t_last_rise = rose;

		r.done_res  = t_done;
		r.done_rose = rose;
		r.done_fell = fell;
		r.running   = run;
		r.count     = t_acc;
		r.flash_out = (m == MODE_FLASHER) && en && (t_acc <= t_on_time);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		// Cap the log; every mismatch still counts
		if (errors <= 40)
			$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Receiver: stall at random, at the rate the current phase asks
	always @(negedge clk)
		res_ch.ready = ($urandom_range(99) >= snk_idle);

	// Compare every result transfer against the oldest awaited result
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited.size() == 0) begin
				report_mismatch("result with nothing awaited", res_ch.count, 32'd0);
			end else begin
				want = awaited.pop_front();
				results_checked++;
				if (res_ch.done_rose === 1'b1)
					done_pulses++;
				if (res_ch.done_res !== want.done_res)
					report_mismatch("done_res", res_ch.done_res, want.done_res);
				if (res_ch.done_rose !== want.done_rose)
					report_mismatch("done_rose", res_ch.done_rose, want.done_rose);
				if (res_ch.done_fell !== want.done_fell)
					report_mismatch("done_fell", res_ch.done_fell, want.done_fell);
				if (res_ch.running !== want.running)
					report_mismatch("running", res_ch.running, want.running);
				if (res_ch.count !== want.count)
					report_mismatch("count", res_ch.count, want.count);
				if (res_ch.flash_out !== want.flash_out)
					report_mismatch("flash_out", res_ch.flash_out, want.flash_out);
			end
		end
	end

	// Watchdog: end the run if it goes far past any correct duration
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results still awaited", cycles, awaited.size());
		$display("FAIL");
		$finish;
	end

	// Send one scan: idle at random first, then hold it until the transfer
	task automatic send_scan(input logic [ELAPSED_BITS-1:0] el, input logic en,
		input logic rq, input logic ct);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			scan_ch.valid = 1'b0;
			@(negedge clk);
		end
		scan_ch.valid     = 1'b1;
		scan_ch.elapsed   = el;
		scan_ch.enable    = en;
		scan_ch.reset_req = rq;
		scan_ch.control   = ct;
		@(posedge clk);
		while (!scan_ch.ready)
			@(posedge clk);
		awaited.push_back(advance_timer(el, en, rq, ct));
		scans_sent++;
	endtask

	// Drop valid and hold off until every awaited result is in, plus a margin
	task automatic wait_idle();
		@(negedge clk);
		scan_ch.valid = 1'b0;
		while (awaited.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write one register; call only while the block is idle
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		write_en    = 1'b1;
		write_index = idx;
		write_data  = val;
		@(posedge clk);
		case (idx)
			CFG_MODE: begin
				t_mode = val[MODE_BITS-1:0];
				modes_seen[val[MODE_BITS-1:0]] = 1'b1;
			end
			CFG_PRESET:  t_preset  = val;
			CFG_ON_TIME: t_on_time = val;
			default: ;
		endcase
		settings_used++;
		@(negedge clk);
		write_en = 1'b0;
	endtask

	// Change all three registers, one after another, between phases
	task automatic set_timer(input logic [MODE_BITS-1:0] m,
		input logic [CFG_DATA_BITS-1:0] pre, input logic [CFG_DATA_BITS-1:0] ont);
		wait_idle();
		write_reg(CFG_MODE, CFG_DATA_BITS'(m));
		write_reg(CFG_PRESET, pre);
		write_reg(CFG_ON_TIME, ont);
	endtask

	// Reset values: on-delay, preset 1000, on_time 0
	task automatic test_reset_values();
		send_scan(16'hFFFF, 1'b1, 1'b0, 1'b0);   // clamp at the default preset
		send_scan(16'h0000, 1'b0, 1'b0, 1'b0);   // enable low clears done
	endtask

	// Unused selector code with a zero preset
	task automatic test_unused_mode();
		set_timer(MODE_UNUSED, 32'd0, 32'hFFFF_FFFF);
		send_scan(16'd0, 1'b1, 1'b0, 1'b0);      // zero preset is reached at once
		send_scan(16'd5, 1'b0, 1'b0, 1'b1);      // runs on control, cleared by enable low
	endtask

	// Off-delay, ending with control high so the latch carries into latched mode
	task automatic test_off_delay();
		set_timer(MODE_OFF_DELAY, 32'd10, 32'd0);
		send_scan(16'd3, 1'b1, 1'b0, 1'b0);
		send_scan(16'd4, 1'b0, 1'b0, 1'b1);
		send_scan(16'd7, 1'b0, 1'b0, 1'b0);      // reach the preset, done falls
		send_scan(16'd2, 1'b0, 1'b1, 1'b1);      // reset_req sets done again
	endtask

	// Latched: start latch inherited, reset only while done
	task automatic test_latched();
		set_timer(MODE_LATCHED, 32'd6, 32'd0);
		send_scan(16'd2, 1'b0, 1'b0, 1'b0);
		send_scan(16'd3, 1'b0, 1'b1, 1'b0);
		send_scan(16'd2, 1'b0, 1'b0, 1'b1);
		send_scan(16'd5, 1'b0, 1'b0, 1'b0);
	endtask

	// Retentive, with the preset lowered below the held count
	task automatic test_retentive();
		set_timer(MODE_RETENTIVE, 32'd20, 32'd0);
		send_scan(16'd8, 1'b1, 1'b0, 1'b0);
		send_scan(16'd5, 1'b0, 1'b0, 1'b1);
		wait_idle();
		write_reg(CFG_PRESET, 32'd10);
		send_scan(16'd0, 1'b0, 1'b0, 1'b0);      // count stays above the new preset
		send_scan(16'd0, 1'b1, 1'b0, 1'b0);      // next running scan clamps it
		send_scan(16'd0, 1'b0, 1'b1, 1'b0);
	endtask

	// Pulse: the scan after the done rise clears the timer
	task automatic test_pulse();
		set_timer(MODE_PULSE, 32'd5, 32'd0);
		send_scan(16'd6, 1'b1, 1'b0, 1'b0);
		send_scan(16'd1, 1'b1, 1'b0, 1'b0);
		send_scan(16'd5, 1'b1, 1'b0, 1'b0);
	endtask

	// Retriggerable: both control edges restart
	task automatic test_retrig();
		set_timer(MODE_RETRIG, 32'd100, 32'd0);
		send_scan(16'd10, 1'b0, 1'b0, 1'b1);
		send_scan(16'd10, 1'b0, 1'b0, 1'b0);
		send_scan(16'd10, 1'b0, 1'b0, 1'b1);
	endtask

	// Flasher: output high up to on_time, restart after the done rise
	task automatic test_flasher();
		set_timer(MODE_FLASHER, 32'd8, 32'd3);
		send_scan(16'd2, 1'b1, 1'b0, 1'b0);
		send_scan(16'd4, 1'b1, 1'b0, 1'b0);
		send_scan(16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_scan(16'd1, 1'b1, 1'b0, 1'b0);
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] pick_preset();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		if (r < 75)
			return $urandom_range(1, 300);
		return $urandom_range(301, 2000000);
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_on_time();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 30)
			return '1;
		if (r < 45)
			return $urandom;
		return t_preset >> $urandom_range(0, 3);
	endfunction

	// Mostly steps small against the preset so timing runs over many scans
	function automatic logic [ELAPSED_BITS-1:0] pick_elapsed();
		int unsigned r;
		logic [31:0] span;
		r = $urandom_range(99);
		span = (t_preset >> 2) + 32'd1;
		if (span > 32'd65535 || span == 32'd0)
			span = 32'd65535;
		if (r < 4)
			return '1;
		if (r < 8)
			return '0;
		if (r < 20)
			return ELAPSED_BITS'($urandom);
		return ELAPSED_BITS'($urandom_range(0, span));
	endfunction

	// Random scans over every mode code: enable and control are held levels that
	// toggle now and then, reset_req pulses rarely
	task automatic test_random_scans(input int unsigned src_pct, input int unsigned snk_pct,
		input int unsigned per_setting);
		int unsigned k, n, base;
		logic en, ct;
		base = $urandom_range(7);
		for (k = 0; k < 8; k++) begin
			wait_idle();
			src_idle = src_pct;
			snk_idle = snk_pct;
			write_reg(CFG_MODE, CFG_DATA_BITS'((base + k) % 8));
			write_reg(CFG_PRESET, pick_preset());
			write_reg(CFG_ON_TIME, pick_on_time());
			en = 1'($urandom_range(1));
			ct = 1'($urandom_range(1));
			for (n = 0; n < per_setting; n++) begin
				if ($urandom_range(99) < 15)
					en = !en;
				if ($urandom_range(99) < 15)
					ct = !ct;
				// Hold off the sender until the block has drained
				if (n == per_setting / 2)
					wait_idle();
				send_scan(pick_elapsed(), en, $urandom_range(99) < 8, ct);
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		write_en          = 1'b0;
		write_index       = CFG_MODE;
		write_data        = '0;
		scan_ch.valid     = 1'b0;
		scan_ch.elapsed   = '0;
		scan_ch.enable    = 1'b0;
		scan_ch.reset_req = 1'b0;
		scan_ch.control   = 1'b0;
		res_ch.ready      = 1'b0;

		t_mode          = MODE_ON_DELAY;
		t_preset        = PRESET_RESET;
		t_on_time       = ON_TIME_RESET;
		t_acc           = '0;
		t_done          = 1'b0;
		t_rise_arm      = 1'b0;
		t_fall_arm      = 1'b0;
		t_last_rise     = 1'b0;
		t_ctrl_latch    = 1'b0;
		t_ctrl_rise_arm = 1'b0;
		t_ctrl_fall_arm = 1'b0;

		errors          = 0;
		scans_sent      = 0;
		results_checked = 0;
		settings_used   = 0;
		done_pulses     = 0;
		modes_seen      = 8'b0000_0001;
		src_idle        = 30;
		snk_idle        = 70;

		// Hold reset, then release it away from the rising edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, sender idling 30 percent and receiver 70
		test_reset_values();
		test_unused_mode();
		test_off_delay();
		test_latched();
		test_retentive();
		test_pulse();
		test_retrig();
		test_flasher();

		// Random part: swap the idle rates, then run flat out
		test_random_scans(30, 70, 38);
		test_random_scans(70, 30, 38);
		test_random_scans(0, 0, 38);

		wait_idle();
		repeat (8) @(posedge clk);
		if (awaited.size() != 0)
			report_mismatch("results never delivered", awaited.size(), 32'd0);

		$display("%0d scans transferred, %0d results checked, %0d done rises observed",
			scans_sent, results_checked, done_pulses);
		$display("%0d register writes, mode codes exercised %b", settings_used, modes_seen);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pmt_pkg.sv
rtl/pmt_scan_if.sv
rtl/pmt_result_if.sv
rtl/pmt_step.sv
rtl/multi_mode_plc_timer_unit.sv
sim/tb_top.sv
